FILE: rtl/sscf_pkg.sv
// Shared types, codes and default sizes of the stack cache spill and fill block.
package sscf_pkg;

   // Field widths of the transfer payloads and of the stack base write.
   localparam int MODE_BITS       = 3;
   localparam int COUNT_BITS      = 5;
   localparam int OFFSET_BITS     = 4;
   localparam int WORD_BITS       = 32;
   localparam int STACK_BASE_BITS = 10;

   // Default sizes handed down from the top level.
   localparam int DEFAULT_CACHE_ADDR_BITS = 4;
   localparam int DEFAULT_MEM_ADDR_BITS   = 10;

   // Operation codes carried in the mode field.
   localparam logic [MODE_BITS-1:0] MODE_RESERVE = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_FREE    = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_ENSURE  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_STORE   = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_LOAD    = 3'd4;

   // Request payload.
   typedef struct packed {
      logic [MODE_BITS-1:0]   mode;
      logic [COUNT_BITS-1:0]  count;
      logic [OFFSET_BITS-1:0] offset;
      logic [WORD_BITS-1:0]   write_data;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [WORD_BITS-1:0]  read_data;
      logic [COUNT_BITS-1:0] spilled_words;
      logic [COUNT_BITS-1:0] filled_words;
      logic [COUNT_BITS-1:0] occupancy;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sweep;
      logic accept;
      logic plan;
      logic spill;
      logic fill;
      logic settle;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic                 sweep_last;
      logic                 count_zero;
      logic                 rsp_free;
      logic [MODE_BITS-1:0] mode;
   } status_type;

endpackage

FILE: rtl/sscf_ram.sv
// Generic single write port RAM with one registered read port.
module sscf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

FILE: rtl/sscf_ctrl.sv
// Controller state machine that sequences clearing, planning, spill, fill and response.
module sscf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sscf_pkg::status_type status,
   output sscf_pkg::cmd_type    cmd
);
   import sscf_pkg::*;

   typedef enum logic [6:0] {
      ST_SWEEP  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_PLAN   = 7'b0000100,
      ST_SPILL  = 7'b0001000,
      ST_FILL   = 7'b0010000,
      ST_SETTLE = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            case (status.mode)
               MODE_RESERVE: state_in = ST_SPILL;
               MODE_ENSURE:  state_in = ST_FILL;
               default:      state_in = ST_SETTLE;
            endcase
         end
         ST_SPILL, ST_FILL: begin
            if (status.count_zero) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands decoded from the state.
   always_comb begin
      cmd.sweep  = (state_ff == ST_SWEEP);
      cmd.accept = (state_ff == ST_IDLE) && req_valid;
      cmd.plan   = (state_ff == ST_PLAN);
      cmd.spill  = (state_ff == ST_SPILL);
      cmd.fill   = (state_ff == ST_FILL);
      cmd.settle = (state_ff == ST_SETTLE);
      cmd.finish = (state_ff == ST_DONE) && status.rsp_free;
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: rtl/sscf_datapath.sv
// Datapath: pointers, word counter, cache and backing memories, output register.
module sscf_datapath #(
   parameter int CACHE_ADDR_BITS = sscf_pkg::DEFAULT_CACHE_ADDR_BITS,
   parameter int MEM_ADDR_BITS   = sscf_pkg::DEFAULT_MEM_ADDR_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sscf_pkg::cmd_type                     cmd,
   output sscf_pkg::status_type                  status,
   input  sscf_pkg::req_type                     req_data,
   input  logic                                  csr_write_enable,
   input  logic [sscf_pkg::STACK_BASE_BITS-1:0]  csr_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sscf_pkg::rsp_type                     rsp_data
);
   import sscf_pkg::*;

   localparam int C = CACHE_ADDR_BITS;
   localparam int M = MEM_ADDR_BITS;
   localparam int SW = (C > M) ? C : M;
   localparam int W = ((M > COUNT_BITS) ? M : COUNT_BITS) + 1;
   localparam int CAP = (C < M) ? (1 << C) : ((1 << M) - 1);
   localparam logic [W-1:0] CAP_W = W'(CAP);

   // Registers.
   logic [M-1:0]          stack_top_ff, stack_top_in;
   logic [M-1:0]          memory_top_ff, memory_top_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] spilled_ff, spilled_in;
   logic [COUNT_BITS-1:0] filled_ff, filled_in;
   logic [WORD_BITS-1:0]  rd_ff, rd_in;
   logic [SW-1:0]         sweep_ff, sweep_in;
   logic                  pend_spill_ff, pend_spill_in;
   logic                  pend_fill_ff, pend_fill_in;
   logic [M-1:0]          pend_addr_ff, pend_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   req_type               req_ff, req_in;

   // Memory ports.
   logic                 cache_we;
   logic [C-1:0]         cache_waddr;
   logic [WORD_BITS-1:0] cache_wdata;
   logic [C-1:0]         cache_raddr;
   logic [WORD_BITS-1:0] cache_rdata;
   logic                 back_we;
   logic [M-1:0]         back_waddr;
   logic [WORD_BITS-1:0] back_wdata;
   logic [M-1:0]         back_raddr;
   logic [WORD_BITS-1:0] back_rdata;

   // Derived values.
   logic [M-1:0]          occ;
   logic [W-1:0]          occ_w;
   logic [W-1:0]          n_w;
   logic [W-1:0]          count_w;
   logic [W-1:0]          need_w;
   logic [M-1:0]          n_m;
   logic [M-1:0]          mt_dec;
   logic [M-1:0]          st_inc;
   logic [C-1:0]          access_slot;
   logic                  count_zero;

   always_comb begin
      occ         = memory_top_ff - stack_top_ff;
      occ_w       = W'(occ);
      n_w         = W'(req_ff.count);
      count_w     = W'(req_data.count);
      need_w      = occ_w + n_w;
      n_m         = M'(req_ff.count);
      mt_dec      = memory_top_ff - M'(1);
      st_inc      = stack_top_ff + n_m;
      access_slot = C'(stack_top_ff) + C'(req_ff.offset);
      count_zero  = (count_ff == '0);
   end

   // Next values of the datapath registers.
   always_comb begin
      stack_top_in  = stack_top_ff;
      memory_top_in = memory_top_ff;
      count_in      = count_ff;
      spilled_in    = spilled_ff;
      filled_in     = filled_ff;
      rd_in         = rd_ff;
      sweep_in      = sweep_ff;
      pend_spill_in = 1'b0;
      pend_fill_in  = 1'b0;
      pend_addr_in  = pend_addr_ff;
      req_in        = req_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      cache_we      = 1'b0;
      cache_waddr   = C'(pend_addr_ff);
      cache_wdata   = back_rdata;
      cache_raddr   = C'(mt_dec);
      back_we       = pend_spill_ff;
      back_waddr    = pend_addr_ff;
      back_wdata    = cache_rdata;
      back_raddr    = memory_top_ff;

      // Clearing pass over both memories after reset.
      if (cmd.sweep) begin
         sweep_in    = sweep_ff + SW'(1);
         cache_we    = 1'b1;
         cache_waddr = sweep_ff[C-1:0];
         cache_wdata = '0;
         back_we     = 1'b1;
         back_waddr  = sweep_ff[M-1:0];
         back_wdata  = '0;
      end

      // Capture the request with its count saturated to the capacity.
      if (cmd.accept) begin
         req_in = req_data;
         if (count_w > CAP_W) begin
            req_in.count = COUNT_BITS'(CAP_W);
         end
      end

      // Plan the step: counts, pointer moves, and single-word accesses.
      if (cmd.plan) begin
         spilled_in = '0;
         filled_in  = '0;
         count_in   = '0;
         case (req_ff.mode)
            MODE_RESERVE: begin
               if (need_w > CAP_W) begin
                  count_in   = COUNT_BITS'(need_w - CAP_W);
                  spilled_in = COUNT_BITS'(need_w - CAP_W);
               end
               stack_top_in = stack_top_ff - n_m;
            end
            MODE_FREE: begin
               stack_top_in = st_inc;
               if (occ_w < n_w) begin
                  memory_top_in = st_inc;
               end
            end
            MODE_ENSURE: begin
               if (n_w > occ_w) begin
                  count_in  = COUNT_BITS'(n_w - occ_w);
                  filled_in = COUNT_BITS'(n_w - occ_w);
               end
            end
            MODE_STORE: begin
               cache_we    = 1'b1;
               cache_waddr = access_slot;
               cache_wdata = req_ff.write_data;
            end
            MODE_LOAD: begin
               cache_raddr = access_slot;
            end
            default: begin
            end
         endcase
      end

      // Spill one word per cycle; the backing write follows from the registered pending address and cache read.
      if (cmd.spill && !count_zero) begin
         memory_top_in = mt_dec;
         pend_spill_in = 1'b1;
         pend_addr_in  = mt_dec;
         count_in      = count_ff - COUNT_BITS'(1);
      end

      // Fill one word per cycle; the cache write follows from the registered pending address and backing read.
      if (pend_fill_ff) begin
         cache_we = 1'b1;
      end
      if (cmd.fill && !count_zero) begin
         memory_top_in = memory_top_ff + M'(1);
         pend_fill_in  = 1'b1;
         pend_addr_in  = memory_top_ff;
         count_in      = count_ff - COUNT_BITS'(1);
      end

      // Take the loaded word once the read has returned.
      if (cmd.settle) begin
         rd_in = (req_ff.mode == MODE_LOAD) ? cache_rdata : '0;
      end

      // Output register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.read_data       = rd_ff;
         rsp_data_in.spilled_words   = spilled_ff;
         rsp_data_in.filled_words    = filled_ff;
         rsp_data_in.occupancy       = COUNT_BITS'(occ);
      end

      // A stack base write empties the window.
      if (csr_write_enable) begin
         stack_top_in  = M'(csr_write_data);
         memory_top_in = M'(csr_write_data);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_top_ff  <= '0;
         memory_top_ff <= '0;
         count_ff      <= '0;
         sweep_ff      <= '0;
         pend_spill_ff <= 1'b0;
         pend_fill_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         stack_top_ff  <= stack_top_in;
         memory_top_ff <= memory_top_in;
         count_ff      <= count_in;
         sweep_ff      <= sweep_in;
         pend_spill_ff <= pend_spill_in;
         pend_fill_ff  <= pend_fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      spilled_ff   <= spilled_in;
      filled_ff    <= filled_in;
      rd_ff        <= rd_in;
      pend_addr_ff <= pend_addr_in;
      req_ff       <= req_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Stack cache words.
   sscf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (1 << C)
   ) u_cache (
      .clock         (clock),
      .write_enable  (cache_we),
      .write_address (cache_waddr),
      .write_data    (cache_wdata),
      .read_address  (cache_raddr),
      .read_data     (cache_rdata)
   );

   // Backing word store.
   sscf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (1 << M)
   ) u_backing (
      .clock         (clock),
      .write_enable  (back_we),
      .write_address (back_waddr),
      .write_data    (back_wdata),
      .read_address  (back_raddr),
      .read_data     (back_rdata)
   );

   always_comb begin
      status.sweep_last = (sweep_ff == {SW{1'b1}});
      status.count_zero = count_zero;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
      status.mode       = req_ff.mode;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/stack_cache_spill_fill.sv
// Top level of the stack cache with spill to and fill from a backing word store.
//
// Requests arrive on req_valid/req_stall with a req_data payload; one transfer carries
// one operation (reserve, free, ensure, store word, load word). Every request yields
// exactly one response on rsp_valid/rsp_stall with rsp_data. One request is worked
// on at a time; req_stall is low only while the block is idle.
// Spill and fill move one word per cycle through the registered memory read ports.
// A finished response sits in an output register; while rsp_stall is high it holds
// and the block keeps the following request waiting in its done state.
// After reset both memories are cleared to zero, one entry per cycle, as a sweep address
// runs from 0 to 2^max(CACHE_ADDR_BITS, MEM_ADDR_BITS) - 1 (1023 with the defaults);
// requests are stalled during that pass. A write on csr_write_enable sets the stack top
// and memory top to csr_write_data, which empties the window; write only while idle.
module stack_cache_spill_fill #(
   parameter int CACHE_ADDR_BITS = sscf_pkg::DEFAULT_CACHE_ADDR_BITS,
   parameter int MEM_ADDR_BITS   = sscf_pkg::DEFAULT_MEM_ADDR_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sscf_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sscf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [sscf_pkg::STACK_BASE_BITS-1:0] csr_write_data
);
   import sscf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   sscf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Pointers, counters and memories.
   sscf_datapath #(
      .CACHE_ADDR_BITS (CACHE_ADDR_BITS),
      .MEM_ADDR_BITS   (MEM_ADDR_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule
